/* rtl/core/swsp_pkg.sv */
package swsp_pkg;

	localparam int MAX_WINDOW    = 4096;
	localparam int ALPHABET_SIZE = 26;

	localparam int SYM_W   = 5;
	localparam int LEN_W   = 13;
	localparam int CNT_W   = 13;
	localparam int MASK_W  = ALPHABET_SIZE;
	localparam int HIST_AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One command word handed from the front to the back.
	typedef struct packed {
		logic             clr;
		logic             take;
		logic             retire;
		logic             emit;
		logic [SYM_W-1:0] sym;
		logic [SYM_W-1:0] old;
	} cmd_t;

	typedef struct packed {
		logic              valid;
		logic [QCNT_W-1:0] count;
	} q_status_t;

endpackage

/* rtl/core/sliding_window_symbol_presence_unit.sv */
// Channel   Direction  Handshake                Payload
// input     in         push / full              symbol[4:0], start_flag
// result    out        pop / empty              presence_mask[25:0]
// config    in         window_length_we         window_length[12:0]
//
// One word is accepted per cycle while full is low; the history memory read and
// write and the per-letter counter update each happen in their own stage.
// A result goes through the stage-one registers and the command queue to the output.
// Reset clears pointers, fill count, counters and the window length (to one).
// The front stalls only when the four-entry command queue, counting the word in
// stage one, is full, and the back stalls only on a result word that meets a full,
// unpopped output register.
module sliding_window_symbol_presence_unit import swsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [SYM_W-1:0]  symbol,
	input  logic              start_flag,
	output logic              empty,
	input  logic              pop,
	output logic [MASK_W-1:0] presence_mask,
	input  logic              window_length_we,
	input  logic [LEN_W-1:0]  window_length
);

	q_status_t q_stat;
	cmd_t      push_cmd;
	cmd_t      head_cmd;
	logic      q_push;
	logic      q_pop;

	swsp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.symbol          (symbol),
		.start_flag      (start_flag),
		.window_length_we(window_length_we),
		.window_length   (window_length),
		.q_stat          (q_stat),
		.q_push          (q_push),
		.q_cmd           (push_cmd)
	);

	swsp_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_push),
		.wr_cmd(push_cmd),
		.rd    (q_pop),
		.rd_cmd(head_cmd),
		.stat  (q_stat)
	);

	swsp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (window_length_we),
		.q_stat       (q_stat),
		.q_cmd        (head_cmd),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.presence_mask(presence_mask)
	);

endmodule

/* rtl/core/swsp_ram.sv */
module swsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read and a write of the same address return the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/swsp_front.sv */
module swsp_front import swsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [SYM_W-1:0] symbol,
	input  logic             start_flag,
	input  logic             window_length_we,
	input  logic [LEN_W-1:0] window_length,
	input  q_status_t        q_stat,
	output logic             q_push,
	output cmd_t             q_cmd
);

	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   fill_q;
	logic [HIST_AW-1:0] wp_q;

	logic [LEN_W-1:0]   len_eff;
	logic [LEN_W-1:0]   fill_base;
	logic [LEN_W-1:0]   fill_inc;
	logic [LEN_W-1:0]   fill_next;
	logic [HIST_AW-1:0] wp_base;
	logic [HIST_AW-1:0] wp_next;
	logic [HIST_AW-1:0] old_addr;
	logic [QCNT_W:0]    used;
	logic               accept;
	logic               sym_ok;
	logic               win_full;
	logic               emit;

	logic               valid_s1;
	logic               clr_s1;
	logic               take_s1;
	logic               retire_s1;
	logic               emit_s1;
	logic [SYM_W-1:0]   sym_s1;
	logic [SYM_W-1:0]   hist_rdata;

	// The word in stage one always finds room, so it is counted against the queue.
	assign used   = {1'b0, q_stat.count} + (QCNT_W + 1)'(valid_s1);
	assign full   = used >= (QCNT_W + 1)'(QDEPTH);
	assign accept = push && !full;

	assign sym_ok    = symbol < SYM_W'(ALPHABET_SIZE);
	assign fill_base = start_flag ? '0 : fill_q;
	assign wp_base   = start_flag ? '0 : wp_q;
	assign fill_inc  = fill_base + LEN_W'(1);
	assign win_full  = fill_base >= len_q;
	assign emit      = sym_ok && (win_full || (fill_inc == len_q));
	assign fill_next = (sym_ok && !win_full) ? fill_inc : fill_base;
	assign wp_next   = sym_ok ? wp_base + HIST_AW'(1) : wp_base;
	// The oldest symbol sits one window length behind the write slot.
	assign old_addr  = wp_base - len_q[HIST_AW-1:0];

	always_comb begin
		if (window_length == '0) begin
			len_eff = LEN_W'(1);
		end else if (window_length > LEN_W'(MAX_WINDOW)) begin
			len_eff = LEN_W'(MAX_WINDOW);
		end else begin
			len_eff = window_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_W'(1);
			fill_q <= '0;
			wp_q   <= '0;
		end else if (window_length_we) begin
			len_q  <= len_eff;
			fill_q <= '0;
			wp_q   <= '0;
		end else if (accept) begin
			fill_q <= fill_next;
			wp_q   <= wp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && (sym_ok || start_flag);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clr_s1    <= start_flag;
			take_s1   <= sym_ok;
			retire_s1 <= sym_ok && win_full;
			emit_s1   <= emit;
			sym_s1    <= symbol;
		end
	end

	swsp_ram #(
		.WIDTH(SYM_W),
		.DEPTH(MAX_WINDOW)
	) u_hist (
		.clk  (clk),
		.we   (accept && sym_ok),
		.waddr(wp_base),
		.wdata(symbol),
		.raddr(old_addr),
		.rdata(hist_rdata)
	);

	assign q_push = valid_s1;

	always_comb begin
		q_cmd.clr    = clr_s1;
		q_cmd.take   = take_s1;
		q_cmd.retire = retire_s1;
		q_cmd.emit   = emit_s1;
		q_cmd.sym    = sym_s1;
		q_cmd.old    = hist_rdata;
	end

endmodule

/* rtl/core/swsp_queue.sv */
module swsp_queue import swsp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  cmd_t      wr_cmd,
	input  logic      rd,
	output cmd_t      rd_cmd,
	output q_status_t stat
);

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_rd;

	assign do_rd = rd && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!wr && do_rd) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	assign rd_cmd     = entry_q[rd_ptr_q];
	assign stat.valid = count_q != '0;
	assign stat.count = count_q;

endmodule

/* rtl/core/swsp_back.sv */
module swsp_back import swsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  q_status_t         q_stat,
	input  cmd_t              q_cmd,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output logic [MASK_W-1:0] presence_mask
);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	logic [CNT_W-1:0]  cnt_q [ALPHABET_SIZE];
	logic [CNT_W-1:0]  cnt_d [ALPHABET_SIZE];
	logic [MASK_W-1:0] mask_d;
	logic [MASK_W-1:0] mask_q;
	logic              out_valid_q;
	logic              advance;

	// A word without a result never waits for the output register.
	assign advance = q_stat.valid && (!q_cmd.emit || !out_valid_q || pop);
	assign q_pop   = advance;

	// Each letter keeps its own counter; a letter is present while its count is nonzero.
	always_comb begin
		logic [CNT_W-1:0] base;
		logic [CNT_W-1:0] after_dec;
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			base      = q_cmd.clr ? '0 : cnt_q[i];
			after_dec = base;
			if (q_cmd.retire && (q_cmd.old == SYM_W'(i)) && (base != '0)) begin
				after_dec = base - CNT_W'(1);
			end
			cnt_d[i] = after_dec;
			if (q_cmd.take && (q_cmd.sym == SYM_W'(i)) && (after_dec != CNT_MAX)) begin
				cnt_d[i] = after_dec + CNT_W'(1);
			end
			mask_d[i] = cnt_d[i] != '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (clear) begin
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (advance) begin
			for (int i = 0; i < ALPHABET_SIZE; i++) begin
				cnt_q[i] <= cnt_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && q_cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && q_cmd.emit) begin
			mask_q <= mask_d;
		end
	end

	assign empty         = !out_valid_q;
	assign presence_mask = mask_q;

endmodule

/* tb/tb.sv */
module tb;
	import swsp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             start;
	} letter_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [SYM_W-1:0]  symbol = '0;
	logic              start_flag = 1'b0;
	logic              empty;
	logic              pop = 1'b0;
	logic [MASK_W-1:0] presence_mask;
	logic              window_length_we = 1'b0;
	logic [LEN_W-1:0]  window_length = '0;

	sliding_window_symbol_presence_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.symbol           (symbol),
		.start_flag       (start_flag),
		.empty            (empty),
		.pop              (pop),
		.presence_mask    (presence_mask),
		.window_length_we (window_length_we),
		.window_length    (window_length)
	);

	always #6 clk = ~clk;

	// Shadow copy of the window state.
	logic [CNT_W-1:0]   letter_count [ALPHABET_SIZE];
	logic [SYM_W-1:0]   letter_history [MAX_WINDOW];
	logic [LEN_W-1:0]   fill_level;
	logic [HIST_AW-1:0] write_slot;
	logic [MASK_W-1:0]  live_mask;
	logic [LEN_W-1:0]   window_setting;

	letter_word_t      pending_words [$];
	logic [MASK_W-1:0] mask_expected [$];
	int                errors = 0;

	function automatic void clear_window_state();
		for (int i = 0; i < ALPHABET_SIZE; i++)
			letter_count[i] = '0;
		fill_level = '0;
		write_slot = '0;
		live_mask = '0;
	endfunction

	function automatic void apply_window_length(input logic [LEN_W-1:0] value);
		window_setting = value;
		clear_window_state();
	endfunction

	function automatic bit predict_mask(input logic [SYM_W-1:0] sym, input logic start,
			output logic [MASK_W-1:0] mask_out);
		int unsigned        span;
		logic [HIST_AW-1:0] oldest_slot;
		logic [SYM_W-1:0]   oldest;
		span = (window_setting == 0) ? 1 :
			(window_setting > MAX_WINDOW) ? MAX_WINDOW : window_setting;
		mask_out = '0;
		if (start)
			clear_window_state();
		if (sym >= ALPHABET_SIZE)
			return 1'b0;
		if (fill_level >= span) begin
			oldest_slot = write_slot - HIST_AW'(span);
			oldest = letter_history[oldest_slot];
			if (oldest < ALPHABET_SIZE && letter_count[oldest] > 0) begin
				letter_count[oldest]--;
				if (letter_count[oldest] == 0)
					live_mask[oldest] = 1'b0;
			end
		end else begin
			fill_level++;
		end
		letter_history[write_slot] = sym;
		write_slot++;
		if (letter_count[sym] != '1)
			letter_count[sym]++;
		live_mask[sym] = 1'b1;
		mask_out = live_mask;
		return fill_level >= span;
	endfunction

	task automatic note_failure(input string what, input logic [MASK_W-1:0] want,
			input logic [MASK_W-1:0] got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s: expected mask %h, got %h", $realtime, what, want, got);
	endtask

	// Result checking and input prediction, both on the rising edge.
	logic [MASK_W-1:0] predicted;
	logic [MASK_W-1:0] oldest_expected;
	letter_word_t      taken;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (mask_expected.size() == 0) begin
					note_failure("result word with nothing expected", 'x, presence_mask);
				end else begin
					oldest_expected = mask_expected.pop_front();
					if (presence_mask !== oldest_expected)
						note_failure("presence_mask mismatch", oldest_expected, presence_mask);
				end
			end
			if (push && !full) begin
				taken = pending_words.pop_front();
				if (predict_mask(taken.sym, taken.start, predicted))
					mask_expected.push_back(predicted);
			end
		end
	end

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(40, 1);
				gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
			end
			if (burst_left > 0) begin
				burst_left--;
				if (pending_words.size() != 0) begin
					push <= 1'b1;
					symbol <= pending_words[0].sym;
					start_flag <= pending_words[0].start;
				end else begin
					push <= 1'b0;
				end
			end else begin
				gap_left--;
				push <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, armed once by the stimulus.
	bit hold_arm = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	always @(posedge clk) begin
		if (hold_arm && !hold_done) begin
			hold_left = 400;
			hold_done = 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
		end
	end

	// Receiver: the stall pattern switches between a few modes.
	int pop_mode = 0;
	int pop_left = 0;
	bit pop_wish;

	always @(negedge clk) begin
		if (pop_left == 0) begin
			pop_mode = $urandom_range(3, 0);
			pop_left = $urandom_range(256, 32);
		end else begin
			pop_left--;
		end
		case (pop_mode)
			0: pop_wish = 1'b1;
			1: pop_wish = 1'($urandom_range(1, 0));
			2: pop_wish = ($urandom_range(3, 0) == 0);
			default: pop_wish = ($urandom_range(7, 0) != 0);
		endcase
		pop <= pop_wish && (hold_left == 0);
	end

	task automatic queue_word(input logic [SYM_W-1:0] sym, input logic start);
		letter_word_t w;
		w.sym = sym;
		w.start = start;
		pending_words.push_back(w);
	endtask

	// Strings of letters drawn from a random slice of the alphabet; a string
	// usually opens with a start flag, and noisy runs sprinkle in ignored words.
	task automatic queue_strings(input int total, input int min_len, input int max_len,
			input bit noisy);
		int valid_n;
		int len;
		int span;
		int base;
		valid_n = 0;
		while (valid_n < total) begin
			len = $urandom_range(max_len, min_len);
			span = ($urandom_range(2, 0) == 0) ? ALPHABET_SIZE : $urandom_range(5, 1);
			base = $urandom_range(ALPHABET_SIZE - span, 0);
			for (int i = 0; i < len; i++) begin
				if (noisy && $urandom_range(19, 0) == 0)
					queue_word(SYM_W'($urandom_range(31, ALPHABET_SIZE)),
						1'($urandom_range(1, 0)));
				queue_word(SYM_W'(base + $urandom_range(span - 1, 0)),
					(i == 0) && ($urandom_range(3, 0) != 0));
				valid_n++;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || mask_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_window_length(input logic [LEN_W-1:0] value);
		@(negedge clk);
		window_length_we <= 1'b1;
		window_length <= value;
		apply_window_length(value);
		@(negedge clk);
		window_length_we <= 1'b0;
	endtask

	int cycle_count = 0;

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int k;
		window_setting = 1;
		clear_window_state();
		for (int i = 0; i < MAX_WINDOW; i++)
			letter_history[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Window of one after reset: extreme letters, ignored symbols, start flags.
		queue_word(0, 0);
		queue_word(ALPHABET_SIZE - 1, 0);
		queue_word(ALPHABET_SIZE, 0);
		queue_word(31, 1);
		queue_word(0, 1);
		queue_word(13, 0);
		wait_drained();

		// Window of three: fill, retire with repeats, restart mid-stream.
		write_window_length(3);
		queue_word(0, 0);
		queue_word(1, 0);
		queue_word(0, 0);
		queue_word(2, 0);
		queue_word(2, 0);
		queue_word(2, 0);
		queue_word(30, 0);
		queue_word(5, 1);
		queue_word(27, 1);
		queue_word(1, 0);
		queue_word(1, 0);
		queue_word(1, 0);
		wait_drained();

		// A length of zero behaves as a length of one.
		write_window_length(0);
		queue_word(7, 0);
		queue_word(31, 0);
		queue_word(ALPHABET_SIZE - 1, 1);
		wait_drained();

		write_window_length(1);
		hold_arm = 1'b1;
		queue_strings(200, 1, 6, 1);
		wait_drained();

		write_window_length(2);
		queue_strings(200, 1, 8, 1);
		wait_drained();

		repeat (3) begin
			k = $urandom_range(40, 3);
			write_window_length(LEN_W'(k));
			queue_strings(200, 1, 3 * k + 2, 1);
			wait_drained();
		end

		k = $urandom_range(120, 41);
		write_window_length(LEN_W'(k));
		queue_strings(200, k / 2, 3 * k, 1);
		wait_drained();

		write_window_length(ALPHABET_SIZE);
		queue_strings(200, 1, 80, 1);
		wait_drained();

		// The largest window never fills here, so no word may come out.
		write_window_length(MAX_WINDOW);
		queue_strings(250, 250, 250, 0);
		wait_drained();

		// An all-ones length saturates to the largest window, which stays unfilled.
		write_window_length('1);
		queue_strings(150, 150, 150, 0);
		wait_drained();

		if (mask_expected.size() != 0)
			note_failure("expected word never arrived", mask_expected[0], 'x);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
